>>> sv/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg
// Shared codes, status values and controller/datapath signal groups for the
// cursor list record store.
// ----------------------------------------------------------------------------
package cls_pkg;

  // command codes
  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_ADVANCE = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_SHOW    = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOCUR = 2'd2;

  // record layout: name low, name mid, name high, age, sex, gpa
  localparam int REC_W = 64 + 64 + 32 + 8 + 8 + 16;

  // controller to datapath commands
  typedef struct packed {
    logic       latch;     // capture input beat, clear scan
    logic       scan_inc;  // step free-slot scan
    logic       app_wr;    // write record into scanned slot
    logic       app_link;  // link old tail to new slot
    logic       rd_ptr;    // link read at walk pointer (else at cursor)
    logic       adv_upd;   // cursor takes its successor
    logic       del_head;  // unlink head under cursor
    logic       walk_init; // start predecessor walk at head
    logic       walk_step; // follow one link
    logic       del_link;  // unlink cursor behind predecessor
    logic       clear_all; // empty the list
    logic       show_out;  // present record under cursor
    logic       finish;    // emit result beat
    logic [1:0] status;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] cmd;
    logic       cur_null;
    logic       head_null;
    logic       scan_free;
    logic       scan_last;
    logic       cur_is_head;
    logic       link_hit;
    logic       link_end;
    logic       steps_max;
  } sts_t;

  // byte mask for the stored part of a name word
  function automatic logic [63:0] name_mask(input int base, input int nbytes, input int len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < nbytes && base + b < len) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

>>> sv/cursor_list_record_store.sv
// ----------------------------------------------------------------------------
// cursor_list_record_store
// Fixed-capacity singly linked list of student records with a cursor:
// append, advance, delete, show and clear, one command per beat.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------
//  input    | start, busy        | in_cmd, in_name_bytes_*, age, sex, gpa
//  result   | out_valid (strobe) | out_status, out_record_valid, record
//
//  Clear and unknown commands finish in decode; advance and show go on to
//  their own state unless there is no cursor. Append scans for a free slot,
//  one slot a cycle, then writes the link if the list was not empty. The
//  predecessor walk does one link read per step over the single read port.
//  Reset is synchronous, active low; it empties the list at once.
//  A result is on the ports for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module cursor_list_record_store import cls_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int NAME_LENGTH = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [63:0] in_name_bytes_low,
  input  logic [63:0] in_name_bytes_mid,
  input  logic [31:0] in_name_bytes_high,
  input  logic [7:0]  in_age_in,
  input  logic [7:0]  in_sex_in,
  input  logic [15:0] in_gpa_in,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_record_valid,
  output logic [63:0] out_name_out_low,
  output logic [63:0] out_name_out_mid,
  output logic [31:0] out_name_out_high,
  output logic [7:0]  out_age_out,
  output logic [7:0]  out_sex_out,
  output logic [15:0] out_gpa_out
);

  ctl_t ctl;
  sts_t sts;

  cls_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  cls_dpath #(.CAPACITY(CAPACITY), .NAME_LENGTH(NAME_LENGTH)) u_dpath (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_cmd(in_cmd), .in_name_bytes_low(in_name_bytes_low),
    .in_name_bytes_mid(in_name_bytes_mid), .in_name_bytes_high(in_name_bytes_high),
    .in_age_in(in_age_in), .in_sex_in(in_sex_in), .in_gpa_in(in_gpa_in),
    .out_valid(out_valid), .out_status(out_status),
    .out_record_valid(out_record_valid),
    .out_name_out_low(out_name_out_low), .out_name_out_mid(out_name_out_mid),
    .out_name_out_high(out_name_out_high), .out_age_out(out_age_out),
    .out_sex_out(out_sex_out), .out_gpa_out(out_gpa_out)
  );

endmodule

>>> sv/cls_ram.sv
// ----------------------------------------------------------------------------
// cls_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cls_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/cls_ctrl.sv
// ----------------------------------------------------------------------------
// cls_ctrl
// Command sequencer: decodes the latched command and steps the datapath
// through scan, write, link read and predecessor walk.
// ----------------------------------------------------------------------------
module cls_ctrl import cls_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_LINK, S_ADV, S_DNXT, S_WRD, S_WCHK, S_SHOW
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.status = ST_DONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.cmd)
          CMD_APPEND: state_nxt = S_SCAN;
          CMD_ADVANCE: begin
            if (sts.cur_null) begin
              ctl.finish = 1'b1; ctl.status = ST_NOCUR; state_nxt = S_IDLE;
            end else begin
              state_nxt = S_ADV;
            end
          end
          CMD_DELETE: begin
            if (sts.cur_null || sts.head_null) begin
              ctl.finish = 1'b1; ctl.status = ST_NOCUR; state_nxt = S_IDLE;
            end else begin
              state_nxt = S_DNXT;
            end
          end
          CMD_SHOW: begin
            if (sts.cur_null) begin
              ctl.finish = 1'b1; ctl.status = ST_NOCUR; state_nxt = S_IDLE;
            end else begin
              state_nxt = S_SHOW;
            end
          end
          CMD_CLEAR: begin
            ctl.clear_all = 1'b1; ctl.finish = 1'b1; state_nxt = S_IDLE;
          end
          default: begin
            ctl.finish = 1'b1; state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.scan_free) begin
          ctl.app_wr = 1'b1;
          if (sts.head_null) begin
            ctl.finish = 1'b1; state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LINK;
          end
        end else if (sts.scan_last) begin
          ctl.finish = 1'b1; ctl.status = ST_FULL; state_nxt = S_IDLE;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_LINK: begin
        ctl.app_link = 1'b1; ctl.finish = 1'b1; state_nxt = S_IDLE;
      end
      S_ADV: begin
        ctl.adv_upd = 1'b1; ctl.finish = 1'b1; state_nxt = S_IDLE;
      end
      S_DNXT: begin
        if (sts.cur_is_head) begin
          ctl.del_head = 1'b1; ctl.finish = 1'b1; state_nxt = S_IDLE;
        end else begin
          ctl.walk_init = 1'b1; state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        ctl.rd_ptr = 1'b1; state_nxt = S_WCHK;
      end
      S_WCHK: begin
        if (sts.link_hit) begin
          ctl.del_link = 1'b1; ctl.finish = 1'b1; state_nxt = S_IDLE;
        end else if (sts.steps_max || sts.link_end) begin
          ctl.finish = 1'b1; ctl.status = ST_NOCUR; state_nxt = S_IDLE;
        end else begin
          ctl.walk_step = 1'b1; state_nxt = S_WRD;
        end
      end
      S_SHOW: begin
        ctl.show_out = 1'b1; ctl.finish = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |=> !busy) else $error("finish did not return to idle");
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.app_link, ctl.del_head, ctl.del_link, ctl.adv_upd, ctl.clear_all}))
    else $error("conflicting list updates");

endmodule

>>> sv/cls_dpath.sv
// ----------------------------------------------------------------------------
// cls_dpath
// List datapath: record and link RAMs, slot-in-use bits, head, tail, cursor
// and walk registers, result registers.
// ----------------------------------------------------------------------------
module cls_dpath import cls_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int NAME_LENGTH = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_t        ctl,
  output sts_t        sts,
  input  logic [2:0]  in_cmd,
  input  logic [63:0] in_name_bytes_low,
  input  logic [63:0] in_name_bytes_mid,
  input  logic [31:0] in_name_bytes_high,
  input  logic [7:0]  in_age_in,
  input  logic [7:0]  in_sex_in,
  input  logic [15:0] in_gpa_in,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_record_valid,
  output logic [63:0] out_name_out_low,
  output logic [63:0] out_name_out_mid,
  output logic [31:0] out_name_out_high,
  output logic [7:0]  out_age_out,
  output logic [7:0]  out_sex_out,
  output logic [15:0] out_gpa_out
);

  localparam int IW = $clog2(CAPACITY);
  localparam int SW = $clog2(CAPACITY + 1);
  localparam logic [SW-1:0] NIL = SW'(CAPACITY);
  localparam logic [63:0] MASK_LOW  = name_mask(0, 8, NAME_LENGTH);
  localparam logic [63:0] MASK_MID  = name_mask(8, 8, NAME_LENGTH);
  localparam logic [63:0] MASK_HIGH = name_mask(16, 4, NAME_LENGTH);

  logic [2:0]      cmd_r;
  logic [REC_W-1:0] rec_in_r;
  logic [IW-1:0]   scan_r;
  logic [SW-1:0]   head_r, tail_r, cur_r, ptr_r, nxt_r, steps_r;
  logic [CAPACITY-1:0] in_use_r;

  logic            rec_we, link_we;
  logic [IW-1:0]   link_waddr, link_raddr;
  logic [SW-1:0]   link_wdata, link_rdata, scan_slot;
  logic [REC_W-1:0] rec_rdata;

  assign scan_slot = SW'(scan_r);

  // record and link storage
  assign rec_we = ctl.app_wr;

  cls_ram #(.W(REC_W), .D(CAPACITY)) u_rec_ram (
    .clk(clk), .we(rec_we), .waddr(scan_r), .wdata(rec_in_r),
    .raddr(cur_r[IW-1:0]), .rdata(rec_rdata)
  );

  always_comb begin
    link_we    = ctl.app_wr | ctl.app_link | ctl.del_link;
    link_waddr = scan_r;
    link_wdata = NIL;
    if (ctl.app_link) begin
      link_waddr = tail_r[IW-1:0];
      link_wdata = scan_slot;
    end else if (ctl.del_link) begin
      link_waddr = ptr_r[IW-1:0];
      link_wdata = nxt_r;
    end
  end

  assign link_raddr = ctl.rd_ptr ? ptr_r[IW-1:0] : cur_r[IW-1:0];

  cls_ram #(.W(SW), .D(CAPACITY)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  // latch input beat
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r    <= in_cmd;
      rec_in_r <= {in_name_bytes_low & MASK_LOW, in_name_bytes_mid & MASK_MID,
                   in_name_bytes_high & MASK_HIGH[31:0], in_age_in, in_sex_in, in_gpa_in};
    end
  end

  // list registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= NIL;
      tail_r   <= NIL;
      cur_r    <= NIL;
      in_use_r <= '0;
      scan_r   <= '0;
    end else begin
      if (ctl.latch)    scan_r <= '0;
      if (ctl.scan_inc) scan_r <= scan_r + 1'b1;
      if (ctl.app_wr) begin
        in_use_r[scan_r] <= 1'b1;
        if (head_r == NIL) begin
          head_r <= scan_slot;
          tail_r <= scan_slot;
          cur_r  <= scan_slot;
        end
      end
      if (ctl.app_link) tail_r <= scan_slot;
      if (ctl.adv_upd)  cur_r  <= link_rdata;
      if (ctl.del_head) begin
        head_r <= link_rdata;
        cur_r  <= link_rdata;
        if (tail_r == cur_r) tail_r <= NIL;
        in_use_r[cur_r[IW-1:0]] <= 1'b0;
      end
      if (ctl.del_link) begin
        cur_r <= nxt_r;
        if (tail_r == cur_r) tail_r <= ptr_r;
        in_use_r[cur_r[IW-1:0]] <= 1'b0;
      end
      if (ctl.clear_all) begin
        head_r   <= NIL;
        tail_r   <= NIL;
        cur_r    <= NIL;
        in_use_r <= '0;
      end
    end
  end

  // predecessor walk
  always_ff @(posedge clk) begin
    if (ctl.walk_init) begin
      nxt_r   <= link_rdata;
      ptr_r   <= head_r;
      steps_r <= '0;
    end
    if (ctl.walk_step) begin
      ptr_r   <= link_rdata;
      steps_r <= steps_r + 1'b1;
    end
  end

  // status to controller
  always_comb begin
    sts.cmd         = cmd_r;
    sts.cur_null    = (cur_r >= NIL);
    sts.head_null   = (head_r >= NIL);
    sts.scan_free   = !in_use_r[scan_r];
    sts.scan_last   = (scan_slot == NIL - 1'b1);
    sts.cur_is_head = (cur_r == head_r);
    sts.link_hit    = (link_rdata == cur_r);
    sts.link_end    = (link_rdata >= NIL);
    sts.steps_max   = (steps_r == NIL);
  end

  // result beat
  logic        out_valid_r, out_record_valid_r;
  logic [1:0]  out_status_r;
  logic [REC_W-1:0] out_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= ctl.finish;
    out_status_r       <= ctl.status;
    out_record_valid_r <= ctl.show_out;
    out_rec_r          <= ctl.show_out ? rec_rdata : '0;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_record_valid = out_record_valid_r;
  assign {out_name_out_low, out_name_out_mid, out_name_out_high,
          out_age_out, out_sex_out, out_gpa_out} = out_rec_r;

  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r == NIL |-> tail_r == NIL) else $error("tail set on empty list");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("back-to-back result strobes");
  a_rec_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_record_valid_r |-> out_status_r == ST_DONE)
    else $error("record shown with error status");

endmodule
